// ===== rtl/core/page_visibility_flag_table_core_defines.svh =====
// Assertion macros shared by the page visibility table RTL.
`ifndef PAGE_VISIBILITY_FLAG_TABLE_CORE_DEFINES_SVH
`define PAGE_VISIBILITY_FLAG_TABLE_CORE_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define PVFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define PVFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pvft_pkg.sv =====
// Shared constants, request codes and control structs of the page visibility table.
package pvft_pkg;

  localparam int unsigned PVFT_CAPACITY     = 64;
  localparam int unsigned PVFT_PAGE_ID_BITS = 32;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned PAGE_W  = 32;
  localparam int unsigned COUNT_W = 7;

  // Flag pair layout: bit 0 is visible, bit 1 is frozen.
  localparam int unsigned FLAG_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET_VISIBLE = 3'd0,
    REQ_SET_FROZEN  = 3'd1,
    REQ_CLEAR_FLAGS = 3'd2,
    REQ_REMOVE      = 3'd3,
    REQ_CLEAR_ALL   = 3'd4,
    REQ_QUERY       = 3'd5
  } req_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic fetch;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_remove;
  } status_t;

endpackage

// ===== rtl/core/pvft_datapath.sv =====
// Datapath: entry memory, sequential lookup, counters and result register.
`include "page_visibility_flag_table_core_defines.svh"

module pvft_datapath import pvft_pkg::*; #(
  parameter int unsigned CAPACITY     = PVFT_CAPACITY,
  parameter int unsigned PAGE_ID_BITS = PVFT_PAGE_ID_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [PAGE_W-1:0]  page_id_i,
  input  cmd_t               cmd_i,
  output status_t            st_o,
  output logic               found_o,
  output logic               page_visible_o,
  output logic               page_frozen_o,
  output logic [COUNT_W-1:0] entry_count_o,
  output logic [COUNT_W-1:0] visible_total_o,
  output logic [COUNT_W-1:0] frozen_total_o,
  output logic               insert_dropped_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = PAGE_ID_BITS + FLAG_W;
  localparam int unsigned XW = (PAGE_ID_BITS > PAGE_W) ? PAGE_ID_BITS : PAGE_W;
  localparam logic [CW-1:0] CapVal = CW'(CAPACITY);

  logic [EW-1:0]           entry_mem_q [CAPACITY];
  logic [EW-1:0]           rdata_q;
  logic [REQ_W-1:0]        op_q;
  logic [PAGE_ID_BITS-1:0] key_q;
  logic [CW-1:0]           idx_q;
  logic                    cmp_vld_q;
  logic [AW-1:0]           cmp_idx_q;
  logic                    hit_q;
  logic [AW-1:0]           slot_q;
  logic [FLAG_W-1:0]       old_q;
  logic [CW-1:0]           held_q, held_d;
  logic [CW-1:0]           vis_q, vis_d;
  logic [CW-1:0]           frz_q, frz_d;

  logic [XW-1:0]     id_ext;
  logic              issue;
  logic              match;
  logic              fetch_en;
  logic              rd_en;
  logic [CW-1:0]     last_idx;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wa;
  logic [EW-1:0]     wd;
  logic [FLAG_W-1:0] want;
  logic [FLAG_W-1:0] new_f;
  logic [FLAG_W-1:0] flags_after;
  logic              dropped;

  assign id_ext   = XW'(page_id_i);
  assign issue    = cmd_i.scan && (idx_q < held_q);
  assign match    = cmd_i.scan && cmp_vld_q && (rdata_q[PAGE_ID_BITS-1:0] == key_q);
  assign last_idx = held_q - CW'(1);
  assign fetch_en = cmd_i.fetch && (held_q != '0);
  assign rd_en    = issue || fetch_en;
  assign rd_addr  = cmd_i.fetch ? last_idx[AW-1:0] : idx_q[AW-1:0];

  assign st_o.scan_done = match || !issue;
  assign st_o.is_remove = (op_q == REQ_REMOVE);

  assign want  = (op_q == REQ_SET_FROZEN) ? 2'b11 : 2'b01;
  assign new_f = old_q | want;

  always_comb begin
    held_d      = held_q;
    vis_d       = vis_q;
    frz_d       = frz_q;
    we          = 1'b0;
    wa          = slot_q;
    wd          = {new_f, key_q};
    flags_after = '0;
    dropped     = 1'b0;
    case (op_q)
      REQ_SET_VISIBLE, REQ_SET_FROZEN: begin
        if (hit_q) begin
          we          = 1'b1;
          vis_d       = vis_q - CW'(old_q[0]) + CW'(new_f[0]);
          frz_d       = frz_q - CW'(old_q[1]) + CW'(new_f[1]);
          flags_after = new_f;
        end else if (held_q < CapVal) begin
          // The new page goes to the end of the table.
          we          = 1'b1;
          wa          = held_q[AW-1:0];
          wd          = {want, key_q};
          held_d      = held_q + CW'(1);
          vis_d       = vis_q + CW'(want[0]);
          frz_d       = frz_q + CW'(want[1]);
          flags_after = want;
        end else begin
          dropped = 1'b1;
        end
      end
      REQ_CLEAR_FLAGS: begin
        if (hit_q) begin
          we    = 1'b1;
          wd    = {2'b00, key_q};
          vis_d = vis_q - CW'(old_q[0]);
          frz_d = frz_q - CW'(old_q[1]);
        end
      end
      REQ_REMOVE: begin
        if (hit_q) begin
          // The last entry, fetched beforehand, fills the freed slot.
          we     = 1'b1;
          wd     = rdata_q;
          held_d = last_idx;
          vis_d  = vis_q - CW'(old_q[0]);
          frz_d  = frz_q - CW'(old_q[1]);
        end
      end
      REQ_CLEAR_ALL: begin
        held_d = '0;
        vis_d  = '0;
        frz_d  = '0;
      end
      default: begin
        if (hit_q) begin
          flags_after = old_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && we) begin
      entry_mem_q[wa] <= wd;
    end
    if (rd_en) begin
      rdata_q <= entry_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      hit_q     <= 1'b0;
      slot_q    <= '0;
      old_q     <= '0;
      held_q    <= '0;
      vis_q     <= '0;
      frz_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
      end else begin
        cmp_vld_q <= issue;
        if (issue) begin
          idx_q     <= idx_q + CW'(1);
          cmp_idx_q <= idx_q[AW-1:0];
        end
        if (match) begin
          hit_q  <= 1'b1;
          slot_q <= cmp_idx_q;
          old_q  <= rdata_q[EW-1:PAGE_ID_BITS];
        end
      end
      if (cmd_i.commit) begin
        held_q <= held_d;
        vis_q  <= vis_d;
        frz_q  <= frz_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_type_i;
      key_q <= id_ext[PAGE_ID_BITS-1:0];
    end
    if (cmd_i.commit) begin
      found_o          <= hit_q;
      page_visible_o   <= flags_after[0];
      page_frozen_o    <= flags_after[1];
      entry_count_o    <= COUNT_W'(held_d);
      visible_total_o  <= COUNT_W'(vis_d);
      frozen_total_o   <= COUNT_W'(frz_d);
      insert_dropped_o <= dropped;
    end
  end

  `PVFT_ASSERT_NOW(a_held_within_cap, 1'b1, held_q <= CapVal, "entry count above capacity")
  `PVFT_ASSERT_NOW(a_vis_within_held, 1'b1, vis_q <= held_q, "visible total above entry count")
  `PVFT_ASSERT_NOW(a_frz_within_vis, 1'b1, frz_q <= vis_q, "frozen total above visible total")

endmodule

// ===== rtl/core/pvft_ctrl.sv =====
// Controller: request sequencing and result handshake of the page visibility table.
`include "page_visibility_flag_table_core_defines.svh"

module pvft_ctrl import pvft_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_UPDATE
  } state_e;

  state_e state_q;
  logic   out_vld_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;

  assign cmd_o.load   = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.scan   = (state_q == ST_SCAN);
  assign cmd_o.fetch  = (state_q == ST_FETCH);
  assign cmd_o.commit = (state_q == ST_UPDATE) && (!out_vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (st_i.scan_done) begin
            state_q <= st_i.is_remove ? ST_FETCH : ST_UPDATE;
          end
        end
        ST_FETCH: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (cmd_o.commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cmd_o.commit) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  `PVFT_ASSERT_NEXT(a_accept_then_busy, in_valid_i && !in_stall_o, in_stall_o, "no busy after accept")
  `PVFT_ASSERT_NEXT(a_commit_shows_result, cmd_o.commit, out_valid_o, "result lost after commit")
  `PVFT_ASSERT_NEXT(a_scan_leaves, (state_q == ST_SCAN) && st_i.scan_done, state_q != ST_SCAN, "scan did not end")

endmodule

// ===== rtl/core/page_visibility_flag_table_core.sv =====
// Top level of the page visibility table: controller plus datapath.
//
// The block keeps up to CAPACITY page identifiers, each with a visible and a
// frozen flag. A request beat on the input channel (req_type_i, page_id_i)
// names an operation and a page; each request yields exactly one result beat
// on the output channel with the lookup outcome, the page's flags afterwards
// and the entry, visible and frozen totals.
//
// A request is looked up by a sequential scan of the entry memory, one entry
// per cycle through a single registered read port; a removal also fetches the
// last entry of the table before the update.
// One request is handled at a time; in_stall_o stays high from acceptance
// until the result has been written into the output register.
//
// A finished result sits in the output register while out_stall_i is high.
// The next request can be accepted and scanned meanwhile; its commit waits
// until the register is free. Reset empties the table and clears all totals
// at once; the entry memory itself is not cleared.
`include "page_visibility_flag_table_core_defines.svh"

module page_visibility_flag_table_core import pvft_pkg::*; #(
  parameter int unsigned CAPACITY     = PVFT_CAPACITY,
  parameter int unsigned PAGE_ID_BITS = PVFT_PAGE_ID_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [PAGE_W-1:0]  page_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic               page_visible_o,
  output logic               page_frozen_o,
  output logic [COUNT_W-1:0] entry_count_o,
  output logic [COUNT_W-1:0] visible_total_o,
  output logic [COUNT_W-1:0] frozen_total_o,
  output logic               insert_dropped_o
);

  // Commands flow from the controller to the datapath, status back.
  cmd_t    cmd;
  status_t status;

  pvft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .st_i        (status),
    .cmd_o       (cmd)
  );

  pvft_datapath #(
    .CAPACITY     (CAPACITY),
    .PAGE_ID_BITS (PAGE_ID_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (req_type_i),
    .page_id_i        (page_id_i),
    .cmd_i            (cmd),
    .st_o             (status),
    .found_o          (found_o),
    .page_visible_o   (page_visible_o),
    .page_frozen_o    (page_frozen_o),
    .entry_count_o    (entry_count_o),
    .visible_total_o  (visible_total_o),
    .frozen_total_o   (frozen_total_o),
    .insert_dropped_o (insert_dropped_o)
  );

  // Port-level checks: a stalled result holds; no early result on accept.
  `PVFT_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o, "result dropped")
  `PVFT_ASSERT_NEXT(a_out_count_holds, out_valid_o && out_stall_i, $stable(entry_count_o), "result moved")
  `PVFT_ASSERT_NEXT(a_busy_no_result, in_valid_i && !in_stall_o && !out_valid_o, !out_valid_o, "early result")

endmodule
